### rtl/huffman_table_encoder_assert.svh
// Assertion macros shared by the encoder's checker.
`ifndef HUFFMAN_TABLE_ENCODER_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hte_pkg.sv
// Types, codes and defaults shared by the Huffman table encoder modules.
package hte_pkg;

  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOLS      = 256;
  localparam int CODE_FIELD_W     = 32;
  localparam int BYTE_W           = 8;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [7:0]              symbol;
    logic [CODE_FIELD_W-1:0] code_bits;
    logic [5:0]              code_length;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_PACK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
    logic flush;
  } pk_ctrl_t;

  typedef struct packed {
    logic done;
  } pk_stat_t;

endpackage

### rtl/huffman_table_encoder.sv
// Top level of the table-driven Huffman encoder and bit packer.
//
//   channel  direction  handshake          word
//   in       input      in_valid/in_ready   hte_pkg::in_word_t
//   out      output     out_valid/out_ready hte_pkg::out_word_t
//
// A load word writes the code memory at acceptance. An encode word reads the table at
// acceptance and loads the shifter in the lookup state, then packs one step per cycle
// while the output slot is free, each step filling the accumulator up to the next byte
// boundary: len 0 still enters the packing state, a 32-bit code takes up to 5 steps.
// A flush word sends any pending partial byte out as the last byte. A stalled output
// word holds the packer in place. Reset clears the table valid bits; no clearing pass.
module huffman_table_encoder #(
  parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOLS      = hte_pkg::DEF_SYMBOLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hte_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hte_pkg::out_word_t out_data
);
  import hte_pkg::*;

  localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int IDX_W  = $clog2(SYMBOLS);

  state_t   state_r, state_nxt;
  pk_ctrl_t ctrl;
  pk_stat_t stat;

  logic              accept;
  logic              sym_ok;
  logic              wr_en;
  logic              rd_en;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] tbl_code;
  logic [LEN_W-1:0]  tbl_len;

  assign accept  = in_valid && in_ready;
  assign sym_ok  = ({1'b0, in_data.symbol} < 9'(SYMBOLS));
  // saturate over-long codes at the stored code width
  assign len_sat = (in_data.code_length > 6'(CODE_W)) ? LEN_W'(CODE_W) :
                   LEN_W'(in_data.code_length);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && sym_ok && (in_data.kind == KIND_ENCODE)) begin
          state_nxt = S_LOOKUP;
        end else if (accept && (in_data.kind == KIND_FLUSH)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_LOOKUP: state_nxt = S_PACK;
      S_PACK: begin
        if (stat.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    ctrl.load  = (state_r == S_LOOKUP);
    ctrl.run   = (state_r == S_PACK);
    ctrl.flush = (state_r == S_FLUSH);
    wr_en      = accept && sym_ok && (in_data.kind == KIND_LOAD);
    rd_en      = accept && sym_ok && (in_data.kind == KIND_ENCODE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  hte_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOLS      (SYMBOLS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (in_data.symbol[IDX_W-1:0]),
    .wr_code (in_data.code_bits[CODE_W-1:0]),
    .wr_len  (len_sat),
    .rd_en   (rd_en),
    .rd_addr (in_data.symbol[IDX_W-1:0]),
    .rd_code (tbl_code),
    .rd_len  (tbl_len)
  );

  hte_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .tbl_code  (tbl_code),
    .tbl_len   (tbl_len),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/hte_table.sv
// Code table: synchronous memory with per-entry valid bits cleared at reset.
module hte_table #(
  parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOLS      = hte_pkg::DEF_SYMBOLS,
  localparam int CODE_W = (MAX_CODE_LEN < hte_pkg::CODE_FIELD_W) ?
                          MAX_CODE_LEN : hte_pkg::CODE_FIELD_W,
  localparam int LEN_W  = $clog2(CODE_W + 1),
  localparam int IDX_W  = $clog2(SYMBOLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [CODE_W-1:0] wr_code,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [CODE_W-1:0] rd_code,
  output logic [LEN_W-1:0]  rd_len
);
  import hte_pkg::*;

  localparam int ENTRY_W = LEN_W + CODE_W;

  logic [ENTRY_W-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0] valid_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_code};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry never loaded reads as zero length.
  assign rd_code = rd_data_r[CODE_W-1:0];
  assign rd_len  = rd_vld_r ? rd_data_r[ENTRY_W-1:CODE_W] : '0;

endmodule

### rtl/hte_packer.sv
// Bit packer: shifts code bits into the byte accumulator and holds the output word.
module hte_packer #(
  parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN,
  localparam int CODE_W = (MAX_CODE_LEN < hte_pkg::CODE_FIELD_W) ?
                          MAX_CODE_LEN : hte_pkg::CODE_FIELD_W,
  localparam int LEN_W  = $clog2(CODE_W + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hte_pkg::pk_ctrl_t  ctrl,
  output hte_pkg::pk_stat_t  stat,
  input  logic [CODE_W-1:0]  tbl_code,
  input  logic [LEN_W-1:0]   tbl_len,
  output logic               out_valid,
  input  logic               out_ready,
  output hte_pkg::out_word_t out_data
);
  import hte_pkg::*;

  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] pend_r, pend_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  out_word_t         od_r, od_nxt;

  logic              slot_free;
  logic [LEN_W-1:0]  free;
  logic [LEN_W-1:0]  take;
  logic [LEN_W-1:0]  rem_after;
  logic [BYTE_W-1:0] top8;
  logic [BYTE_W-1:0] keep;
  logic [BYTE_W-1:0] merged;
  logic [3:0]        sum;
  logic              step_en;

  assign slot_free = !ov_r || out_ready;
  assign free      = LEN_W'(BYTE_W) - LEN_W'(cnt_r);
  assign take      = (rem_r < free) ? rem_r : free;
  assign rem_after = rem_r - take;
  assign top8      = code_r[CODE_W-1 -: BYTE_W];
  assign keep      = top8 & ~(8'hFF >> take);
  assign merged    = pend_r | (keep >> cnt_r);
  assign sum       = {1'b0, cnt_r} + take[3:0];
  assign step_en   = ctrl.run && (rem_r != '0) && slot_free;

  always_comb begin
    code_nxt = code_r;
    rem_nxt  = rem_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;
    stat     = '0;
    if (ctrl.load) begin
      // left-align the code so its first bit sits at the top
      code_nxt = tbl_code << (LEN_W'(CODE_W) - tbl_len);
      rem_nxt  = tbl_len;
    end
    if (ctrl.run) begin
      stat.done = (rem_r == '0) || (step_en && (take == rem_r));
    end
    if (step_en) begin
      code_nxt = code_r << take;
      rem_nxt  = rem_after;
      if (sum[3]) begin
        ov_nxt          = 1'b1;
        od_nxt.out_byte = merged;
        od_nxt.last     = (rem_after < LEN_W'(BYTE_W));
        pend_nxt        = '0;
        cnt_nxt         = '0;
      end else begin
        pend_nxt = merged;
        cnt_nxt  = sum[2:0];
      end
    end
    if (ctrl.flush) begin
      stat.done = slot_free || (cnt_r == '0);
      if (slot_free && (cnt_r != '0)) begin
        ov_nxt          = 1'b1;
        od_nxt.out_byte = pend_r;
        od_nxt.last     = 1'b1;
        pend_nxt        = '0;
        cnt_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

### rtl/hte_checker.sv
// Port-level checker for the Huffman table encoder, bound to the top level.
`include "huffman_table_encoder_assert.svh"

module hte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input hte_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input hte_pkg::out_word_t out_data
);
  import hte_pkg::*;

  // a stalled output word holds
  `HTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

  // a non-final byte means the item is still being packed
  `HTE_ASSERT_SAME(a_busy_mid_item, out_valid && !out_data.last, !in_ready, "input accepted before the last byte of an item")

  // a load never stalls the input
  `HTE_ASSERT_NEXT(a_load_one_cycle, in_valid && in_ready && (in_data.kind == KIND_LOAD), in_ready, "load held the input channel")

endmodule

bind huffman_table_encoder hte_checker u_hte_checker (.*);
